[src/first_fit_heap_allocator_macros.svh]
// Assertion helpers for the checker file.
// All checks sample on clk_i and sleep while rst_ni is low.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// Plain property check.
`define FFHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication check.
`define FFHA_ASSERT_IMPLY(lbl, ante, cons, msg) \
  `FFHA_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication check.
`define FFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  `FFHA_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

[src/ffha_pkg.sv]
`timescale 1ns / 1ps

package ffha_pkg;

  localparam int unsigned HEAP_BYTES_DEF = 4096;
  localparam int unsigned SPLIT_MIN_DEF  = 10;

  // Walk addresses: 13-bit end plus a 16-bit block size plus header.
  localparam int unsigned ADDR_W = 17;
  // Merged size: up to three block sizes plus two headers.
  localparam int unsigned NS_W   = ADDR_W + 1;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_ALLOCATED = 2'd0,
    STAT_NO_SPACE  = 2'd1,
    STAT_FREED     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic {
    CFG_REGION_START = 1'b0,
    CFG_REGION_END   = 1'b1
  } cfg_idx_e;

  // Fit decision for one header during an allocation walk.
  typedef struct packed {
    logic              fit;
    logic              split;
    logic [15:0]       used_hdr;
    logic [15:0]       split_hdr;
    logic [ADDR_W-1:0] split_addr;
  } fit_t;

endpackage

[src/ffha_if.sv]
`timescale 1ns / 1ps

interface ffha_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] req_bytes;
  logic [11:0] block_addr;

  modport source (output valid, output cmd, output req_bytes, output block_addr,
                  input ready);
  modport sink   (input valid, input cmd, input req_bytes, input block_addr,
                  output ready);
endinterface

interface ffha_rsp_if;
  logic        valid;
  logic        ready;
  logic [11:0] payload_addr;
  logic [1:0]  status;

  modport source (output valid, output payload_addr, output status, input ready);
  modport sink   (input valid, input payload_addr, input status, output ready);
endinterface

[src/ffha_fit.sv]
`timescale 1ns / 1ps

module ffha_fit #(
  parameter int unsigned SPLIT_MIN = ffha_pkg::SPLIT_MIN_DEF
) (
  input  logic [15:0]                 hdr_i,
  input  logic [16:0]                 count_i,
  input  logic [ffha_pkg::ADDR_W-1:0] p_i,
  output ffha_pkg::fit_t              fit_o
);
  import ffha_pkg::*;

  logic [16:0] size;
  logic [16:0] left;

  always_comb begin
    size             = {1'b0, hdr_i[15:1], 1'b0};
    left             = size - count_i;
    fit_o.fit        = hdr_i[0] && (size >= count_i);
    fit_o.split      = left > 17'(SPLIT_MIN);
    fit_o.used_hdr   = fit_o.split ? count_i[15:0] : size[15:0];
    // left is even and above two: (left - 2) with the free flag
    fit_o.split_hdr  = {left[15:1] - 15'd1, 1'b1};
    fit_o.split_addr = p_i + ADDR_W'(count_i) + ADDR_W'(2);
  end

endmodule

[src/first_fit_heap_allocator.sv]
// Per item: ST_IDLE accepts; an alloc builds the heap in ST_BUILD if it needs building, then
// reads (ST_RD) and checks (ST_CHK) headers in turn until one fits or the region ends; a
// split adds ST_SPLIT. A free walks alike until the address matches or the region ends
// (+ST_FNRD, ST_FNX to read the following header for merging), or goes straight to ST_DONE
// before the heap is built. One item at a time: the next item is accepted in ST_IDLE,
// entered as the result is registered; a full output register holds the walk in ST_DONE.
// Reset (async, low): no heap built, region 0..4096, output empty; RAM left as is.
`timescale 1ns / 1ps

module first_fit_heap_allocator #(
  parameter int unsigned HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF,
  parameter int unsigned SPLIT_MIN  = ffha_pkg::SPLIT_MIN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [12:0] cfg_wdata_i,
  ffha_req_if.sink    req_i,
  ffha_rsp_if.source  rsp_o
);
  import ffha_pkg::*;

  localparam int unsigned DEPTH = HEAP_BYTES / 2;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] HEAP_LIM = ADDR_W'(HEAP_BYTES - HEAP_BYTES % 2);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_BUILD = 8'b0000_0010,
    ST_RD    = 8'b0000_0100,
    ST_CHK   = 8'b0000_1000,
    ST_SPLIT = 8'b0001_0000,
    ST_FNRD  = 8'b0010_0000,
    ST_FNX   = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_e;

  // header word slot for a byte address
  function automatic logic [IDX_W-1:0] slot(input logic [ADDR_W-1:0] a);
    return a[IDX_W:1];
  endfunction

  // control state
  state_e      state_q, state_d;
  logic        needs_init_q;
  logic [11:0] rs_q;
  logic [12:0] re_q;
  logic        out_valid_q;

  // per-item working registers
  logic              cmd_q;
  logic [16:0]       count_q;
  logic [11:0]       addr_q;
  logic [ADDR_W-1:0] p_q, prev_p_q, nxt_q, target_q;
  logic [15:0]       prev_h_q;
  logic [NS_W-1:0]   newsize_q;
  logic [11:0]       res_payload_q, out_payload_q;
  status_e           res_status_q, out_status_q;

  // header RAM: one write and one registered read per cycle
  logic [15:0]      mem [DEPTH];
  logic [15:0]      rd_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa, mem_ra;
  logic [15:0]      mem_wd;

  // region bounds; the end clamps to the store size
  logic [ADDR_W-1:0] lo, hi, hi_raw;
  logic [ADDR_W-1:0] size_w, nxt_w, p_plus2;
  logic [NS_W-1:0]   cur_size, prev_size, merge_size, fin_size;
  logic [16:0]       count_in;
  logic              accept, out_free, match, merge_prev, walk_end;
  fit_t              fit;

  assign lo       = ADDR_W'({rs_q[11:1], 1'b0});
  assign hi_raw   = ADDR_W'({re_q[12:1], 1'b0});
  assign hi       = (hi_raw > HEAP_LIM) ? HEAP_LIM : hi_raw;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign count_in = {17'({1'b0, req_i.req_bytes} + 17'd1)} & ~17'd1;

  // header decode for the word just read
  assign size_w     = ADDR_W'({rd_q[15:1], 1'b0});
  assign nxt_w      = p_q + size_w + ADDR_W'(2);
  assign p_plus2    = p_q + ADDR_W'(2);
  assign walk_end   = p_q >= hi;
  assign match      = p_plus2 == ADDR_W'(addr_q);
  assign merge_prev = (p_q != lo) && prev_h_q[0];
  assign cur_size   = NS_W'({rd_q[15:1], 1'b0});
  assign prev_size  = NS_W'({prev_h_q[15:1], 1'b0});
  assign merge_size = merge_prev ? (prev_size + cur_size + NS_W'(2)) : cur_size;
  // rd_q here holds the header after the freed block
  assign fin_size   = newsize_q + (rd_q[0] ? (cur_size + NS_W'(2)) : NS_W'(0));

  ffha_fit #(
    .SPLIT_MIN(SPLIT_MIN)
  ) u_fit (
    .hdr_i  (rd_q),
    .count_i(count_q),
    .p_i    (p_q),
    .fit_o  (fit)
  );

  assign req_i.ready        = state_q == ST_IDLE;
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.payload_addr = out_payload_q;
  assign rsp_o.status       = out_status_q;

  // sequencer and RAM port control
  always_comb begin
    state_d = state_q;
    mem_we  = 1'b0;
    mem_wa  = slot(p_q);
    mem_wd  = '0;
    mem_ra  = (state_q == ST_FNRD) ? slot(nxt_q) : slot(p_q);
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          if (req_i.cmd == CMD_FREE) begin
            state_d = needs_init_q ? ST_DONE : ST_RD;
          end else begin
            state_d = needs_init_q ? ST_BUILD : ST_RD;
          end
        end
      end
      ST_BUILD: begin
        // one free block over the whole region, if it holds a header
        mem_we  = hi >= lo + ADDR_W'(2);
        mem_wa  = slot(lo);
        mem_wd  = {16'(hi - lo - ADDR_W'(2)) & 16'hFFFE} | 16'h0001;
        state_d = ST_RD;
      end
      ST_RD: begin
        state_d = walk_end ? ST_DONE : ST_CHK;
      end
      ST_CHK: begin
        if (cmd_q == CMD_ALLOC) begin
          if (fit.fit) begin
            mem_we = 1'b1;
            if (fit.split) begin
              mem_wa  = slot(fit.split_addr);
              mem_wd  = fit.split_hdr;
              state_d = ST_SPLIT;
            end else begin
              mem_wd  = fit.used_hdr;
              state_d = ST_DONE;
            end
          end else begin
            state_d = ST_RD;
          end
        end else begin
          if (match) begin
            if (rd_q[0]) begin
              state_d = ST_DONE;           // already free
            end else if (nxt_w < hi) begin
              state_d = ST_FNRD;           // look at the next block first
            end else begin
              mem_we  = 1'b1;
              mem_wa  = slot(merge_prev ? prev_p_q : p_q);
              mem_wd  = {merge_size[15:1], 1'b1};
              state_d = ST_DONE;
            end
          end else begin
            state_d = ST_RD;
          end
        end
      end
      ST_SPLIT: begin
        mem_we  = 1'b1;
        mem_wd  = count_q[15:0];
        state_d = ST_DONE;
      end
      ST_FNRD: begin
        state_d = ST_FNX;
      end
      ST_FNX: begin
        mem_we  = 1'b1;
        mem_wa  = slot(target_q);
        mem_wd  = {fin_size[15:1], 1'b1};
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      needs_init_q <= 1'b1;
      rs_q         <= '0;
      re_q         <= 13'h1000;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        // any bound change rebuilds the heap at the next allocation
        unique case (cfg_idx_i)
          CFG_REGION_START: rs_q <= cfg_wdata_i[11:0];
          CFG_REGION_END:   re_q <= cfg_wdata_i;
          default:          re_q <= re_q;
        endcase
        needs_init_q <= 1'b1;
      end else if (state_q == ST_BUILD) begin
        needs_init_q <= 1'b0;
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_payload_q <= res_payload_q;
      out_status_q  <= res_status_q;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_q         <= req_i.cmd;
          count_q       <= count_in;
          addr_q        <= req_i.block_addr;
          p_q           <= lo;
          res_payload_q <= '0;
          res_status_q  <= STAT_NOT_FOUND;   // free before the heap exists
        end
      end
      ST_RD: begin
        if (walk_end) begin
          res_payload_q <= '0;
          res_status_q  <= (cmd_q == CMD_ALLOC) ? STAT_NO_SPACE : STAT_NOT_FOUND;
        end
      end
      ST_CHK: begin
        if (cmd_q == CMD_ALLOC) begin
          if (fit.fit) begin
            res_payload_q <= p_plus2[11:0];
            res_status_q  <= STAT_ALLOCATED;
          end else begin
            p_q <= nxt_w;
          end
        end else if (match) begin
          res_payload_q <= '0;
          res_status_q  <= rd_q[0] ? STAT_NOT_FOUND : STAT_FREED;
          target_q      <= merge_prev ? prev_p_q : p_q;
          newsize_q     <= merge_size;
          nxt_q         <= nxt_w;
        end else begin
          prev_p_q <= p_q;
          prev_h_q <= rd_q;
          p_q      <= nxt_w;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[src/ffha_checker.sv]
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_macros.svh"

module ffha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid,
  input logic        req_ready,
  input logic        req_cmd,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [11:0] rsp_payload_addr,
  input logic [1:0]  rsp_status
);
  import ffha_pkg::*;

  // commands of items still owed a result, oldest first
  logic       head_cmd_q, tail_cmd_q;
  logic [1:0] cnt_q;
  logic       push, pop, is_free_stat;

  assign push         = req_valid && req_ready;
  assign pop          = rsp_valid && rsp_ready;
  assign is_free_stat = (rsp_status == STAT_FREED) || (rsp_status == STAT_NOT_FOUND);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      head_cmd_q <= 1'b0;
      tail_cmd_q <= 1'b0;
    end else begin
      if (push && !pop) begin
        if (cnt_q == 2'd0) begin
          head_cmd_q <= req_cmd;
        end else begin
          tail_cmd_q <= req_cmd;
        end
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        head_cmd_q <= tail_cmd_q;
        cnt_q      <= cnt_q - 2'd1;
      end else if (pop && push) begin
        if (cnt_q == 2'd1) begin
          head_cmd_q <= req_cmd;
        end else begin
          head_cmd_q <= tail_cmd_q;
          tail_cmd_q <= req_cmd;
        end
      end
    end
  end

  `FFHA_ASSERT_IMPLY(a_rsp_owed, rsp_valid, cnt_q != 2'd0, "result without a pending item")
  `FFHA_ASSERT_IMPLY(a_stat_cmd, rsp_valid, is_free_stat == (head_cmd_q == CMD_FREE), "status does not match command")
  `FFHA_ASSERT_IMPLY(a_zero_addr, rsp_valid && (rsp_status != STAT_ALLOCATED), rsp_payload_addr == 12'd0, "nonzero address on failed or free result")
  `FFHA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload_addr) && $stable(rsp_status), "stalled result changed")

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid       (req_i.valid),
  .req_ready       (req_i.ready),
  .req_cmd         (req_i.cmd),
  .rsp_valid       (rsp_o.valid),
  .rsp_ready       (rsp_o.ready),
  .rsp_payload_addr(rsp_o.payload_addr),
  .rsp_status      (rsp_o.status)
);
